[src/infix_calculator_evaluator_core_macros.svh]
// assertion macros for the checker in ice_checker.sv
`ifndef INFIX_CALCULATOR_EVALUATOR_CORE_MACROS_SVH
`define INFIX_CALCULATOR_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ICE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ice assertion failed");

// next-cycle implication, disabled while rst is high
`define ICE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ice assertion failed");

`endif

[src/ice_pkg.sv]
package ice_pkg;

   // default fixed point format and limits
   localparam int INT_BITS_DEFAULT  = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int MAX_VALUE_BITS    = 48;
   localparam int MUL_CHUNK_BITS    = 16;

   // port widths
   localparam int CHAR_BITS     = 8;
   localparam int RESULT_BITS   = 48;
   localparam int RSP_DATA_BITS = 56;

   // character codes
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [3:0]           DEC_BASE   = 4'd10;

   // pending operator codes
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHAR,
      ST_APPLY,
      ST_LOAD,
      ST_MUL,
      ST_MUL_DONE,
      ST_DIV,
      ST_DIV_DONE,
      ST_POST,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic digit;
      logic init_term;
      logic add_apply;
      logic load_md;
      logic mul_step;
      logic div_step;
      logic mul_done;
      logic div_done;
      logic commit_op;
      logic finish;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_op;
      logic last;
      logic pend_md;
      logic pend_div;
      logic opnd_zero;
      logic out_busy;
   } status_type;

   // value width from the fixed point format
   function automatic int fx_width(int ib, int fb);
      int w;
      w = ib + fb;
      if (w > MAX_VALUE_BITS) begin
         w = MAX_VALUE_BITS;
      end
      return w;
   endfunction

endpackage

[src/ice_controller.sv]
module ice_controller import ice_pkg::*; #(
   parameter int INT_BITS  = INT_BITS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int W         = fx_width(INT_BITS, FRAC_BITS);
   localparam int NUM_W     = W + FRAC_BITS;
   localparam int MUL_STEPS = (W + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
   localparam int CNT_W     = $clog2(NUM_W + 1);

   state_type        state_ff, state_in;
   logic             final_ff, final_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (status.is_op) begin
               state_in = ST_APPLY;
               final_in = 1'b0;
            end else if (status.last) begin
               state_in = ST_APPLY;
               final_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_APPLY: begin
            state_in = status.pend_md ? ST_LOAD : ST_POST;
         end
         ST_LOAD: begin
            cnt_in = '0;
            if (!status.pend_div) begin
               state_in = ST_MUL;
            end else if (status.opnd_zero) begin
               state_in = ST_POST;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_STEPS)) begin
               state_in = ST_MUL_DONE;
            end
         end
         ST_MUL_DONE: begin
            state_in = ST_POST;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            state_in = ST_POST;
         end
         ST_POST: begin
            if (final_ff) begin
               state_in = ST_FINISH;
            end else if (status.last) begin
               state_in = ST_APPLY;
               final_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_CHAR: begin
            cmd.digit = 1'b1;
         end
         ST_APPLY: begin
            cmd.init_term = status.pend_md;
            cmd.add_apply = !status.pend_md;
         end
         ST_LOAD: begin
            cmd.load_md = 1'b1;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
         end
         ST_MUL_DONE: begin
            cmd.mul_done = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_DIV_DONE: begin
            cmd.div_done = 1'b1;
         end
         ST_POST: begin
            cmd.commit_op = !final_ff;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[src/ice_datapath.sv]
module ice_datapath import ice_pkg::*; #(
   parameter int INT_BITS  = INT_BITS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CHAR_BITS-1:0]     req_tdata,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  cmd_type                  cmd,
   output status_type               status
);

   localparam int W         = fx_width(INT_BITS, FRAC_BITS);
   localparam int NUM_W     = W + FRAC_BITS;
   localparam int MUL_STEPS = (W + MUL_CHUNK_BITS - 1) / MUL_CHUNK_BITS;
   localparam int MPAD_W    = MUL_STEPS * MUL_CHUNK_BITS;
   localparam int PP_W      = W + MUL_CHUNK_BITS;
   localparam int PROD_W    = 2 * W;
   localparam int DIG_W     = W + 5;
   localparam int PAD_W     = RSP_DATA_BITS - RESULT_BITS - 1;
   localparam logic [W-1:0] MAX_MAG = {1'b0, {(W-1){1'b1}}};

   // expression state
   logic signed [W-1:0] sum_ff, sum_in;
   logic signed [W-1:0] term_ff, term_in;
   logic [W-1:0]        opnd_ff, opnd_in;
   op_type              pend_ff, pend_in;
   logic                tvalid_ff, tvalid_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CHAR_BITS-1:0]     char_ff, char_in;
   logic                     last_ff, last_in;
   logic [W-1:0]             x_ff, x_in;
   logic                     neg_ff, neg_in;
   logic [MPAD_W-1:0]        mop_ff, mop_in;
   logic [PP_W-1:0]          pp_ff, pp_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [W-2:0]             rem_ff, rem_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // character decode
   op_type     char_op;
   logic       is_digit;
   logic [3:0] digit_val;

   always_comb begin
      case (char_ff)
         CHAR_PLUS:  char_op = OP_ADD;
         CHAR_MINUS: char_op = OP_SUB;
         CHAR_STAR:  char_op = OP_MUL;
         CHAR_SLASH: char_op = OP_DIV;
         default:    char_op = OP_NONE;
      endcase
   end

   assign is_digit  = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign digit_val = 4'(char_ff - CHAR_ZERO);

   // operand times ten plus digit, saturating
   logic [DIG_W-1:0] dig_sum;
   logic             dig_ovf;

   assign dig_sum = DIG_W'(opnd_ff) * DIG_W'(DEC_BASE) + (DIG_W'(digit_val) << FRAC_BITS);
   assign dig_ovf = dig_sum > DIG_W'(MAX_MAG);

   // saturating sum plus term
   logic [W:0]   sat_raw;
   logic         sat_ovf;
   logic [W-1:0] sat_val;

   assign sat_raw = {sum_ff[W-1], sum_ff} + {term_ff[W-1], term_ff};
   assign sat_ovf = sat_raw[W] ^ sat_raw[W-1];
   assign sat_val = sat_ovf ? {sat_raw[W], {(W-1){~sat_raw[W]}}} : sat_raw[W-1:0];

   // term magnitude and negated operand
   logic [W-1:0] term_bits;
   logic [W-1:0] term_mag;
   logic [W-1:0] opnd_neg;

   assign term_bits = term_ff;
   assign term_mag  = term_bits[W-1] ? (~term_bits + W'(1)) : term_bits;
   assign opnd_neg  = ~opnd_ff + W'(1);

   // clamp of a multiply or divide magnitude
   logic [PROD_W-1:0] clamp_src;
   logic [PROD_W-1:0] clamp_limit;
   logic              clamp_ovf;
   logic [W-1:0]      clamp_mag;
   logic [W-1:0]      clamp_val;

   assign clamp_src   = cmd.mul_done ? (acc_ff >> FRAC_BITS) : PROD_W'(quo_ff);
   assign clamp_limit = PROD_W'(MAX_MAG) + PROD_W'(neg_ff);
   assign clamp_ovf   = clamp_src > clamp_limit;
   assign clamp_mag   = clamp_ovf ? clamp_limit[W-1:0] : clamp_src[W-1:0];
   assign clamp_val   = neg_ff ? (~clamp_mag + W'(1)) : clamp_mag;

   // one restoring divide step
   logic [W-1:0] div_trial;
   logic         div_ge;
   logic [W-1:0] div_diff;

   assign div_trial = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge    = div_trial >= opnd_ff;
   assign div_diff  = div_trial - opnd_ff;

   // multiply chunk from the top of the operand shift register
   logic [MUL_CHUNK_BITS-1:0] mul_chunk;

   assign mul_chunk = mop_ff[MPAD_W-1 -: MUL_CHUNK_BITS];

   // next values
   always_comb begin
      sum_in       = sum_ff;
      term_in      = term_ff;
      opnd_in      = opnd_ff;
      pend_in      = pend_ff;
      tvalid_in    = tvalid_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      neg_in       = neg_ff;
      mop_in       = mop_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // input beat
      if (cmd.capture) begin
         char_in = req_tdata;
         last_in = req_tlast;
      end

      // digit accumulate
      if (cmd.digit && is_digit) begin
         if (dig_ovf) begin
            opnd_in = MAX_MAG;
            ovf_in  = 1'b1;
         end else begin
            opnd_in = dig_sum[W-1:0];
         end
      end

      // missing term counts as zero for multiply and divide
      if (cmd.init_term && !tvalid_ff) begin
         term_in   = '0;
         tvalid_in = 1'b1;
      end

      // plus, minus or none: close the term and open a new one
      if (cmd.add_apply) begin
         if (tvalid_ff) begin
            sum_in = sat_val;
            if (sat_ovf) begin
               ovf_in = 1'b1;
            end
         end
         term_in   = (pend_ff == OP_SUB) ? opnd_neg : opnd_ff;
         tvalid_in = 1'b1;
      end

      // load multiply and divide operands
      if (cmd.load_md) begin
         x_in   = term_mag;
         neg_in = term_bits[W-1];
         mop_in = MPAD_W'(opnd_ff);
         pp_in  = '0;
         acc_in = '0;
         num_in = NUM_W'(term_mag) << FRAC_BITS;
         quo_in = '0;
         rem_in = '0;
      end

      // multiply: partial product, then shift and add
      if (cmd.mul_step) begin
         pp_in  = PP_W'(x_ff) * PP_W'(mul_chunk);
         mop_in = mop_ff << MUL_CHUNK_BITS;
         acc_in = (acc_ff << MUL_CHUNK_BITS) + PROD_W'(pp_ff);
      end

      // divide: one quotient bit
      if (cmd.div_step) begin
         rem_in = div_ge ? div_diff[W-2:0] : div_trial[W-2:0];
         num_in = num_ff << 1;
         quo_in = {quo_ff[NUM_W-2:0], div_ge};
      end

      // write clamped product or quotient back to the term
      if (cmd.mul_done || cmd.div_done) begin
         term_in = clamp_val;
         if (clamp_ovf) begin
            ovf_in = 1'b1;
         end
      end

      // operator takes effect
      if (cmd.commit_op) begin
         opnd_in = '0;
         pend_in = char_op;
      end

      // fold the last term into the sum
      if (cmd.finish && tvalid_ff) begin
         sum_in = sat_val;
         if (sat_ovf) begin
            ovf_in = 1'b1;
         end
      end

      // result beat and clear for the next expression
      if (cmd.emit) begin
         rsp_data_in  = {{PAD_W{1'b0}}, ovf_ff, RESULT_BITS'(sum_ff)};
         rsp_valid_in = 1'b1;
         sum_in       = '0;
         term_in      = '0;
         opnd_in      = '0;
         pend_in      = OP_NONE;
         tvalid_in    = 1'b0;
         ovf_in       = 1'b0;
      end
   end

   // expression state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         term_ff      <= '0;
         opnd_ff      <= '0;
         pend_ff      <= OP_NONE;
         tvalid_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         opnd_ff      <= opnd_in;
         pend_ff      <= pend_in;
         tvalid_ff    <= tvalid_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      last_ff     <= last_in;
      x_ff        <= x_in;
      neg_ff      <= neg_in;
      mop_ff      <= mop_in;
      pp_ff       <= pp_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status to the controller
   assign status.is_op     = (char_op != OP_NONE);
   assign status.last      = last_ff;
   assign status.pend_md   = (pend_ff == OP_MUL) || (pend_ff == OP_DIV);
   assign status.pend_div  = (pend_ff == OP_DIV);
   assign status.opnd_zero = (opnd_ff == '0);
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/infix_calculator_evaluator_core.sv]
// channel   dir  data fields (low bit up)                       tlast / tuser
// req_      in   tdata[7:0] char_code                           tlast = last
// rsp_      out  tdata[47:0] result, [48] overflow, [55:49] 0   none
//
// one beat at a time; a digit or ignored character is captured and decoded, + or - is also applied and committed
// a pending * shifts and adds one 16-bit partial product per cycle
// a pending / runs a restoring divide (Q32.16 by default), one quotient bit per cycle
// a beat with tlast adds a second apply when it is an operator, then finishes and emits
// synchronous reset clears the expression and an unsent result; no clearing pass
// a stalled result holds in the output register while the next expression runs
module infix_calculator_evaluator_core import ice_pkg::*; #(
   parameter int INT_BITS  = INT_BITS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CHAR_BITS-1:0]     req_tdata,   // char_code
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata    // result, overflow, zero pad
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   ice_controller #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic and state
   ice_datapath #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[src/ice_checker.sv]
`include "infix_calculator_evaluator_core_macros.svh"

module ice_checker import ice_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // a stalled result beat holds
   `ICE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // padding above the overflow bit stays zero
   `ICE_ASSERT_IMP(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_BITS-1:RESULT_BITS+1] == '0)

   // reset drops any unsent result
   `ICE_ASSERT_NXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid)

   // a character beat keeps the block busy for the next cycle
   `ICE_ASSERT_NXT(a_busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind infix_calculator_evaluator_core ice_checker u_ice_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
